// File: src/petc_pkg.sv
// Shared types and constants of the periodic expiry catch-up timer.
// No dependencies; used by every module of the timer.
package petc_pkg;

    // Time values in ns and stored expiry values
    localparam int TW = 63;
    localparam int EW = 64;
    localparam int OPW = 8;
    localparam int CPUW = 6;
    localparam int CNTW = 16;
    localparam int CFGW = 2;

    localparam logic [OPW-1:0]  OPCODE_PROFILE = 8'd46;
    localparam logic [TW-1:0]   LAG_LIMIT_NS   = 63'd2000000000;
    localparam logic [CNTW-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [TW-1:0]   INTERVAL_RST   = 63'd1000000;

    typedef enum logic [CFGW-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_START    = 2'd1,
        CFG_SAMPLE   = 2'd2,
        CFG_PERCPU   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_START  = 1'b1
    } t_command;

    typedef enum logic {
        DIV_NOW  = 1'b0,
        DIV_DIFF = 1'b1
    } t_div_src;

    // Outcome of one event, selects what goes to the output register
    typedef enum logic [1:0] {
        RES_DROP = 2'd0,
        RES_ACK  = 2'd1,
        RES_ONE  = 2'd2,
        RES_FIRE = 2'd3
    } t_res;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_src div_src;
        logic     arm;
        logic     arm_from_div;
        logic     upd_entry;
        logic     out_load;
        t_res     res;
    } t_cmd;

    typedef struct packed {
        logic op_match;
        logic is_start;
        logic st_zero;
        logic armed;
        logic slot_ok;
        logic sample_mode;
        logic late;
        logic div_done;
    } t_stat;

endpackage

// File: src/periodic_expiry_catchup_timer_core.sv
// Event path, input transfer to result: a sample that fires goes through the read state and
// then waits for the bit-serial divider, as does a start with zero start time; a sample not
// yet due ends after the read state, and any other event goes from decode to the result.
// One event at a time: the result loads once the output register is free, and only then is
// the next transfer taken. Reset (synchronous, active low) disarms the timer and restores the
// configuration defaults; the expiry store needs no clearing pass.
module periodic_expiry_catchup_timer_core #(
    parameter int CPU_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [petc_pkg::CFGW-1:0]   i_cfg_idx,
    input  logic [petc_pkg::TW-1:0]     i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [petc_pkg::OPW-1:0]    i_event_opcode,
    input  logic [petc_pkg::TW-1:0]     i_now,
    input  logic [petc_pkg::CPUW-1:0]   i_cpu_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [petc_pkg::CPUW-1:0]   o_cpu_out,
    output logic [petc_pkg::CNTW-1:0]   o_fire_count,
    output logic                        o_accepted
);

    petc_pkg::t_cmd  cmd;
    petc_pkg::t_stat stat;

    petc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    petc_dp #(
        .CPU_COUNT (CPU_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_event_opcode (i_event_opcode),
        .i_now          (i_now),
        .i_cpu_index    (i_cpu_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_cpu_out      (o_cpu_out),
        .o_fire_count   (o_fire_count),
        .o_accepted     (o_accepted)
    );

endmodule

// File: src/petc_div.sv
// Restoring divider, one quotient bit per cycle, for the expiry timer.
// Depends on petc_pkg for the time width.
module petc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [petc_pkg::TW-1:0]  i_dividend,
    input  logic [petc_pkg::TW-1:0]  i_divisor,
    output logic                     o_done,
    output logic [petc_pkg::TW-1:0]  o_quo,
    output logic [petc_pkg::TW-1:0]  o_rem
);

    localparam int TW = petc_pkg::TW;
    localparam int CW = $clog2(TW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [TW-1:0] r_rem, n_rem;
    logic [TW-1:0] r_quo, n_quo;
    logic [TW-1:0] r_dsr, n_dsr;

    logic [TW:0]   shifted;
    logic [TW+1:0] trial;
    logic          borrow;

    assign shifted = {r_rem, r_quo[TW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};
    assign borrow  = trial[TW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // take the subtracted remainder only when the trial subtract does not borrow
            n_rem = borrow ? shifted[TW-1:0] : trial[TW-1:0];
            n_quo = {r_quo[TW-2:0], ~borrow};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(TW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: src/petc_ctrl.sv
// Sequencing state machine of the expiry timer: handshakes and datapath commands.
// Depends on petc_pkg for the command and status structs.
module petc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  petc_pkg::t_stat  i_stat,
    output petc_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_READ     = 6'b000100,
        S_DIV_ARM  = 6'b001000,
        S_DIV_FIRE = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    petc_pkg::t_res r_res, n_res;
    logic           r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.res   = r_res;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.op_match) begin
                    n_res   = petc_pkg::RES_DROP;
                    n_state = S_DONE;
                end else if (i_stat.is_start) begin
                    if (i_stat.st_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_src   = petc_pkg::DIV_NOW;
                        n_state         = S_DIV_ARM;
                    end else begin
                        o_cmd.arm = 1'b1;
                        n_res     = petc_pkg::RES_ACK;
                        n_state   = S_DONE;
                    end
                end else if (!i_stat.armed || !i_stat.slot_ok) begin
                    n_res   = petc_pkg::RES_DROP;
                    n_state = S_DONE;
                end else if (i_stat.sample_mode) begin
                    n_res   = petc_pkg::RES_ONE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // expiry still ahead of now: no firing
                if (!i_stat.late) begin
                    n_res   = petc_pkg::RES_ACK;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = petc_pkg::DIV_DIFF;
                    n_state         = S_DIV_FIRE;
                end
            end
            S_DIV_ARM: begin
                if (i_stat.div_done) begin
                    o_cmd.arm          = 1'b1;
                    o_cmd.arm_from_div = 1'b1;
                    n_res              = petc_pkg::RES_ACK;
                    n_state            = S_DONE;
                end
            end
            S_DIV_FIRE: begin
                if (i_stat.div_done) begin
                    o_cmd.upd_entry = 1'b1;
                    n_res           = petc_pkg::RES_FIRE;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= petc_pkg::RES_DROP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: src/petc_dp.sv
// Datapath of the expiry timer: config registers, item latch, expiry memory,
// divider and output register. Depends on petc_pkg and petc_div.
module petc_dp #(
    parameter int CPU_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [petc_pkg::CFGW-1:0]   i_cfg_idx,
    input  logic [petc_pkg::TW-1:0]     i_cfg_data,
    input  logic                        i_command,
    input  logic [petc_pkg::OPW-1:0]    i_event_opcode,
    input  logic [petc_pkg::TW-1:0]     i_now,
    input  logic [petc_pkg::CPUW-1:0]   i_cpu_index,
    input  petc_pkg::t_cmd              i_cmd,
    output petc_pkg::t_stat             o_stat,
    output logic [petc_pkg::CPUW-1:0]   o_cpu_out,
    output logic [petc_pkg::CNTW-1:0]   o_fire_count,
    output logic                        o_accepted
);

    localparam int TW   = petc_pkg::TW;
    localparam int EW   = petc_pkg::EW;
    localparam int CNTW = petc_pkg::CNTW;
    localparam int AW   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    // configuration
    logic [TW-1:0] r_interval;
    logic [TW-1:0] r_start_time;
    logic          r_sample_mode;
    logic          r_per_cpu;

    // latched item
    logic                      r_cmd;
    logic [petc_pkg::OPW-1:0]  r_opcode;
    logic [TW-1:0]             r_now;
    logic [petc_pkg::CPUW-1:0] r_cpu;

    // expiry store: entries not written since the last start read as r_first
    logic [EW-1:0]        r_mem [CPU_COUNT];
    logic [CPU_COUNT-1:0] r_vld;
    logic [EW-1:0]        r_first;
    logic                 r_armed;
    logic [EW-1:0]        r_mem_q;
    logic                 r_vld_q;

    logic [TW-1:0] r_diff;

    logic [CNTW-1:0]           r_fire_count;
    logic                      r_accepted;
    logic [petc_pkg::CPUW-1:0] r_cpu_out;

    logic [TW-1:0] iv_eff;
    logic [8:0]    cpu_ext;
    logic [AW-1:0] addr;
    logic [EW-1:0] cur_exp;
    logic [TW-1:0] diff;
    logic [TW-1:0] div_in;
    logic          div_done;
    logic [TW-1:0] div_quo;
    logic [TW-1:0] div_rem;
    logic [EW-1:0] next_exp;
    logic          jump;
    logic [CNTW-1:0] fire_cnt;
    logic [CNTW-1:0] res_count;
    logic            res_acc;

    assign iv_eff  = (r_interval == '0) ? TW'(1) : r_interval;
    assign cpu_ext = {3'b000, r_cpu};
    assign addr    = r_per_cpu ? cpu_ext[AW-1:0] : '0;
    assign cur_exp = r_vld_q ? r_mem_q : r_first;
    assign diff    = r_now - cur_exp[TW-1:0];
    assign div_in  = (i_cmd.div_src == petc_pkg::DIV_DIFF) ? diff : r_now;

    // next boundary strictly after now: now - (x mod iv) + iv
    assign next_exp = ({1'b0, r_now} - {1'b0, div_rem}) + {1'b0, iv_eff};

    // lag beyond the limit after one period: fire once and skip ahead
    assign jump = (r_diff > iv_eff) && ((r_diff - iv_eff) > petc_pkg::LAG_LIMIT_NS);

    always_comb begin
        if (jump) begin
            fire_cnt = CNTW'(1);
        end else if ((|div_quo[TW-1:CNTW]) || (div_quo[CNTW-1:0] == petc_pkg::COUNT_MAX)) begin
            fire_cnt = petc_pkg::COUNT_MAX;
        end else begin
            fire_cnt = div_quo[CNTW-1:0] + 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.res)
            petc_pkg::RES_DROP: begin
                res_count = '0;
                res_acc   = 1'b0;
            end
            petc_pkg::RES_ACK: begin
                res_count = '0;
                res_acc   = 1'b1;
            end
            petc_pkg::RES_ONE: begin
                res_count = CNTW'(1);
                res_acc   = 1'b1;
            end
            petc_pkg::RES_FIRE: begin
                res_count = fire_cnt;
                res_acc   = 1'b1;
            end
            default: begin
                res_count = '0;
                res_acc   = 1'b0;
            end
        endcase
    end

    petc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_in),
        .i_divisor  (iv_eff),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= petc_pkg::INTERVAL_RST;
            r_start_time  <= '0;
            r_sample_mode <= 1'b0;
            r_per_cpu     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                petc_pkg::CFG_INTERVAL: r_interval    <= i_cfg_data;
                petc_pkg::CFG_START:    r_start_time  <= i_cfg_data;
                petc_pkg::CFG_SAMPLE:   r_sample_mode <= i_cfg_data[0];
                petc_pkg::CFG_PERCPU:   r_per_cpu     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_vld   <= '0;
        end else if (i_cmd.arm) begin
            r_armed <= 1'b1;
            r_vld   <= '0;
        end else if (i_cmd.upd_entry) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_opcode <= i_event_opcode;
            r_now    <= i_now;
            r_cpu    <= i_cpu_index;
        end
        if (i_cmd.arm) begin
            r_first <= i_cmd.arm_from_div ? next_exp : {1'b0, r_start_time};
        end
        if (i_cmd.div_start) begin
            r_diff <= diff;
        end
        if (i_cmd.out_load) begin
            r_cpu_out    <= r_cpu;
            r_fire_count <= res_count;
            r_accepted   <= res_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_entry) begin
            r_mem[addr] <= next_exp;
        end
        r_mem_q <= r_mem[addr];
        r_vld_q <= r_vld[addr];
    end

    assign o_stat.op_match    = (r_opcode == petc_pkg::OPCODE_PROFILE);
    assign o_stat.is_start    = (r_cmd == petc_pkg::CMD_START);
    assign o_stat.st_zero     = (r_start_time == '0);
    assign o_stat.armed       = r_armed;
    assign o_stat.slot_ok     = !r_per_cpu || (cpu_ext < 9'(CPU_COUNT));
    assign o_stat.sample_mode = r_sample_mode;
    assign o_stat.late        = (cur_exp <= {1'b0, r_now});
    assign o_stat.div_done    = div_done;

    assign o_cpu_out    = r_cpu_out;
    assign o_fire_count = r_fire_count;
    assign o_accepted   = r_accepted;

endmodule
